[design/skae_pkg.sv]
`default_nettype none
package skae_pkg;

	localparam int unsigned ADDR_W = 4;

	localparam logic [1:0] REG_SAMPLE_PERIOD     = 2'd0;
	localparam logic [1:0] REG_PROCESS_NOISE     = 2'd1;
	localparam logic [1:0] REG_MEASUREMENT_NOISE = 2'd2;

	localparam logic [31:0] SAMPLE_PERIOD_RST     = 32'd17179869;
	localparam logic [30:0] PROCESS_NOISE_RST     = 31'd1048576;
	localparam logic [30:0] MEASUREMENT_NOISE_RST = 31'd589824;

	typedef struct packed {
		logic [31:0] sample_period;
		logic [30:0] process_noise;
		logic [30:0] measurement_noise;
	} skae_cfg_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_UH,
		MUL_DK,
		MUL_SK,
		MUL_TK
	} mul_op_t;

	typedef struct packed {
		logic    take;
		logic    fetch;
		logic    div_step;
		mul_op_t mul;
		logic    cap_uh;
		logic    cap_dk;
		logic    cap_t;
		logic    commit;
	} skae_cmd_t;

	typedef struct packed {
		logic div_last;
	} skae_sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_MUL_UH,
		ST_MUL_DK,
		ST_MUL_SK,
		ST_CAP_T,
		ST_MUL_TK,
		ST_FINISH
	} state_t;

endpackage
`default_nettype wire

[design/skae_regs.sv]
`default_nettype none
module skae_regs (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [skae_pkg::ADDR_W-1:0]   paddr,
	input  wire [31:0]                   pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output skae_pkg::skae_cfg_t          cfg
);
	import skae_pkg::*;

	logic [31:0] sample_period_q;
	logic [30:0] process_noise_q;
	logic [30:0] measurement_noise_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_period_q     <= SAMPLE_PERIOD_RST;
			process_noise_q     <= PROCESS_NOISE_RST;
			measurement_noise_q <= MEASUREMENT_NOISE_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_SAMPLE_PERIOD:     sample_period_q     <= pwdata;
				REG_PROCESS_NOISE:     process_noise_q     <= pwdata[30:0];
				REG_MEASUREMENT_NOISE: measurement_noise_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SAMPLE_PERIOD:     prdata = sample_period_q;
			REG_PROCESS_NOISE:     prdata = {1'b0, process_noise_q};
			REG_MEASUREMENT_NOISE: prdata = {1'b0, measurement_noise_q};
			default:               prdata = 32'd0;
		endcase
	end

	assign cfg.sample_period     = sample_period_q;
	assign cfg.process_noise     = process_noise_q;
	assign cfg.measurement_noise = measurement_noise_q;

endmodule
`default_nettype wire

[design/skae_ctrl.sv]
`default_nettype none
module skae_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  sample_valid,
	output logic                 sample_stall,
	output logic                 result_valid,
	input  wire                  result_stall,
	input  skae_pkg::skae_sts_t  sts,
	output skae_pkg::skae_cmd_t  cmd
);
	import skae_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   result_valid_q;
	logic   out_free;

	assign out_free     = !result_valid_q || !result_stall;
	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (sample_valid) state_d = ST_LOAD;
			ST_LOAD:   state_d = ST_DIV;
			ST_DIV:    if (sts.div_last) state_d = ST_MUL_UH;
			ST_MUL_UH: state_d = ST_MUL_DK;
			ST_MUL_DK: state_d = ST_MUL_SK;
			ST_MUL_SK: state_d = ST_CAP_T;
			ST_CAP_T:  state_d = ST_MUL_TK;
			ST_MUL_TK: state_d = ST_FINISH;
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul = MUL_NONE;
		case (state_q)
			ST_IDLE:   cmd.take = sample_valid;
			ST_LOAD:   cmd.fetch = 1'b1;
			ST_DIV:    cmd.div_step = 1'b1;
			ST_MUL_UH: cmd.mul = MUL_UH;
			ST_MUL_DK: begin
				cmd.mul    = MUL_DK;
				cmd.cap_uh = 1'b1;
			end
			ST_MUL_SK: begin
				cmd.mul    = MUL_SK;
				cmd.cap_dk = 1'b1;
			end
			ST_CAP_T:  cmd.cap_t = 1'b1;
			ST_MUL_TK: cmd.mul = MUL_TK;
			ST_FINISH: cmd.commit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_commit_shows_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free) |=> (result_valid_q && state_q == ST_IDLE))
		else $error("finished word not presented");
	a_div_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !sts.div_last) |=> (state_q == ST_DIV))
		else $error("divider left early");
	a_take_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && sample_valid) |=> (state_q == ST_LOAD))
		else $error("accepted word not loaded");
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.fetch, cmd.div_step, cmd.cap_t, cmd.commit,
			(cmd.mul != MUL_NONE)}))
		else $error("overlapping datapath commands");
`endif

endmodule
`default_nettype wire

[design/skae_dpath.sv]
`default_nettype none
module skae_dpath #(
	parameter int unsigned NUM_AXES  = 2,
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  skae_pkg::skae_cmd_t  cmd,
	output skae_pkg::skae_sts_t  sts,
	input  skae_pkg::skae_cfg_t  cfg,
	input  wire                  axis,
	input  wire signed [31:0]    gyro_rate,
	input  wire signed [31:0]    accel_angle,
	output logic                 axis_out,
	output logic signed [31:0]   angle_estimate,
	output logic [30:0]          error_covariance
);
	import skae_pkg::*;

	localparam int unsigned AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam logic [30:0] P_RST = 31'(64'd4 << FRAC_BITS);

	logic signed [31:0] est_q [NUM_AXES];
	logic [30:0]        cov_q [NUM_AXES];

	logic               axis_q;
	logic signed [31:0] u_q;
	logic signed [31:0] y_q;
	logic signed [31:0] x_q;
	logic [30:0]        p_q;
	logic [31:0]        s_q;
	logic [31:0]        dmag_q;
	logic               dneg_q;
	logic [31:0]        rem_q;
	logic [31:0]        quo_q;
	logic [4:0]         cnt_q;
	logic [63:0]        prod_q;
	logic signed [32:0] uh_q;
	logic signed [32:0] dk_q;
	logic [31:0]        t_q;

	logic               axis_ok;
	logic [AXW-1:0]     idx;
	logic signed [31:0] x_rd;
	logic [30:0]        p_rd;
	logic signed [32:0] diff;
	logic [32:0]        rem_sh;
	logic               rem_ge;
	logic [31:0]        k_val;
	logic [31:0]        umag;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        rnd_sum;
	logic [31:0]        rnd;
	logic signed [34:0] est_sum;
	logic signed [31:0] est_sat;
	logic signed [33:0] pn_sum;
	logic [30:0]        pn_sat;

	assign axis_ok = (AXW'(axis_q) < AXW'(NUM_AXES - 1)) || (AXW'(axis_q) == AXW'(NUM_AXES - 1));
	assign idx     = AXW'(axis_q);
	assign x_rd    = axis_ok ? est_q[idx] : 32'sd0;
	assign p_rd    = axis_ok ? cov_q[idx] : 31'd0;
	assign diff    = {y_q[31], y_q} - {x_rd[31], x_rd};

	assign rem_sh = {rem_q, 1'b0};
	assign rem_ge = (rem_sh >= {1'b0, s_q});
	assign sts.div_last = (cnt_q == 5'd31);

	always_comb begin
		if (cfg.measurement_noise == 31'd0) begin
			k_val = (p_q == 31'd0) ? 32'd0 : 32'hFFFF_FFFF;
		end else begin
			k_val = quo_q;
		end
	end

	assign umag = u_q[31] ? 32'(-{u_q[31], u_q}) : u_q;

	always_comb begin
		case (cmd.mul)
			MUL_UH: begin
				mul_a = umag;
				mul_b = cfg.sample_period;
			end
			MUL_DK: begin
				mul_a = dmag_q;
				mul_b = k_val;
			end
			MUL_SK: begin
				mul_a = s_q;
				mul_b = k_val;
			end
			MUL_TK: begin
				mul_a = t_q;
				mul_b = k_val;
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	assign rnd_sum = prod_q + 64'h0000_0000_8000_0000;
	assign rnd     = rnd_sum[63:32];

	assign est_sum = 35'(x_q) + 35'(uh_q) + 35'(dk_q);
	always_comb begin
		if (est_sum > 35'sh0_7FFF_FFFF) begin
			est_sat = 32'sh7FFF_FFFF;
		end else if (est_sum < -35'sh0_8000_0000) begin
			est_sat = -32'sh8000_0000;
		end else begin
			est_sat = est_sum[31:0];
		end
	end

	assign pn_sum = $signed({3'b000, p_q}) + $signed({3'b000, cfg.process_noise})
		- $signed({2'b00, rnd});
	always_comb begin
		if (pn_sum < 34'sd0) begin
			pn_sat = 31'd0;
		end else if (pn_sum > 34'sh0_7FFF_FFFF) begin
			pn_sat = 31'h7FFF_FFFF;
		end else begin
			pn_sat = pn_sum[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				est_q[i] <= 32'sd0;
				cov_q[i] <= P_RST;
			end
		end else if (cmd.commit && axis_ok) begin
			est_q[idx] <= est_sat;
			cov_q[idx] <= pn_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0;
		end else if (cmd.fetch) begin
			cnt_q <= 5'd0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			axis_q <= axis;
			u_q    <= gyro_rate;
			y_q    <= accel_angle;
		end
		if (cmd.fetch) begin
			x_q    <= x_rd;
			p_q    <= p_rd;
			s_q    <= {1'b0, cfg.measurement_noise} + {1'b0, p_rd};
			dneg_q <= diff[32];
			dmag_q <= diff[32] ? 32'(-diff) : diff[31:0];
			rem_q  <= {1'b0, p_rd};
			quo_q  <= 32'd0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? 32'(rem_sh - {1'b0, s_q}) : rem_sh[31:0];
			quo_q <= {quo_q[30:0], rem_ge};
		end
		if (cmd.mul != MUL_NONE) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.cap_uh) begin
			uh_q <= u_q[31] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
		end
		if (cmd.cap_dk) begin
			dk_q <= dneg_q ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
		end
		if (cmd.cap_t) begin
			t_q <= rnd;
		end
		if (cmd.commit) begin
			axis_out         <= axis_q;
			angle_estimate   <= axis_ok ? est_sat : 32'sd0;
			error_covariance <= axis_ok ? pn_sat : 31'd0;
		end
	end

endmodule
`default_nettype wire

[design/scalar_kalman_attitude_estimator_unit.sv]
// Scalar Kalman one-step predictor for roll and pitch. Each word names an axis and carries a
// gyro rate u and an accelerometer angle y (signed Q16.16); the unit forms the gain
// K = P/(R2+P), returns x + h*u + K*(y-x) saturated to 32 bits and P + R1 - K*K*(R2+P)
// clamped to 0..2^31-1, and keeps both in the axis state. One word is worked at a time: each
// word runs through the radix-2 gain divider (32 steps) and then makes four passes through the
// one shared 32x32 multiplier. A finished result waits in the output register while the next
// word is already taken.
// Registers (APB, 32-bit): 0x0 sample period h (Q0.32), 0x4 R1, 0x8 R2; write only while idle.
`default_nettype none
module scalar_kalman_attitude_estimator_unit #(
	parameter int unsigned NUM_AXES  = 2,
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [skae_pkg::ADDR_W-1:0]  paddr,
	input  wire [31:0]                  pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  wire                         sample_valid,
	output logic                        sample_stall,
	input  wire                         axis,
	input  wire signed [31:0]           gyro_rate,
	input  wire signed [31:0]           accel_angle,
	output logic                        result_valid,
	input  wire                         result_stall,
	output logic                        axis_out,
	output logic signed [31:0]          angle_estimate,
	output logic [30:0]                 error_covariance
);
	import skae_pkg::*;

	skae_cfg_t cfg;
	skae_cmd_t cmd;
	skae_sts_t sts;

	skae_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	skae_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	skae_dpath #(
		.NUM_AXES  (NUM_AXES),
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg              (cfg),
		.axis             (axis),
		.gyro_rate        (gyro_rate),
		.accel_angle      (accel_angle),
		.axis_out         (axis_out),
		.angle_estimate   (angle_estimate),
		.error_covariance (error_covariance)
	);

endmodule
`default_nettype wire
